// ----- sv/cir_pkg.sv -----
// ----------------------------------------------------------------------------
// cir_pkg: shared types and constants for the insertion repair block
// Sizes of the stores, command and status codes, datapath operations and the
// status bundle from the datapath to the controller.
// ----------------------------------------------------------------------------
package cir_pkg;

  localparam int NODE_W        = 6;
  localparam int ROUTE_W       = 4;
  localparam int POS_W         = 5;
  localparam int LEN_W         = 6;
  localparam int TIME_W        = 16;
  localparam int COST_W        = 18;
  localparam int CFG_W         = 5;
  localparam int MAX_NODES     = 64;
  localparam int MAX_ROUTES    = 16;
  localparam int MAX_ROUTE_LEN = 32;

  localparam logic [2:0] CMD_DIST   = 3'd0;
  localparam logic [2:0] CMD_CLIENT = 3'd1;
  localparam logic [2:0] CMD_APPEND = 3'd2;
  localparam logic [2:0] CMD_REPAIR = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FORCED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BAD    = 2'd3;

  localparam logic signed [COST_W-1:0] NO_FEASIBLE = 18'sd131071;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIST_WR, OP_CLIENT_WR, OP_APPEND, OP_READ, OP_READ_CAP,
    OP_BAD, OP_CL_ISSUE, OP_CL_CAP, OP_CL_FIN, OP_ROUTE_INIT, OP_W_ENTRY,
    OP_W_TIM, OP_W_ACC, OP_GAP_INIT, OP_G0, OP_G1, OP_G2, OP_G3, OP_G4, OP_G5,
    OP_G6, OP_NEXT_ROUTE, OP_FIN, OP_FIN_LEN, OP_MV_RD, OP_MV_WR, OP_INS,
    OP_PUBLISH
  } op_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       len_zero;
    logic       scan_last;
    logic       skip;
    logic       gap_last;
    logic       route_last;
    logic       full;
    logic       mv_more;
  } dp_stat_t;

endpackage

// ----- sv/cir_ram.sv -----
// ----------------------------------------------------------------------------
// cir_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/cir_datapath.sv -----
// ----------------------------------------------------------------------------
// cir_datapath: stores, counters and arithmetic of the repair block
// Executes one operation per cycle as told by the controller.
// ----------------------------------------------------------------------------
module cir_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  cir_pkg::op_t           op,
  input  logic                   cfg_wr_en,
  input  logic [4:0]             cfg_wr_data,
  input  logic [2:0]             cmd,
  input  logic [5:0]             node_a,
  input  logic [5:0]             node_b,
  input  logic [15:0]            distance,
  input  logic [15:0]            window_early,
  input  logic [15:0]            window_late,
  input  logic [15:0]            service_time,
  input  logic [15:0]            release_at,
  input  logic [15:0]            dispatch_by,
  input  logic [3:0]             route_sel,
  input  logic [4:0]             position,
  output cir_pkg::dp_stat_t      stat,
  output logic [1:0]             status,
  output logic [3:0]             chosen_route,
  output logic [5:0]             chosen_position,
  output logic signed [17:0]     delta_cost,
  output logic [5:0]             read_client,
  output logic [5:0]             route_length
);

  // item
  logic [2:0]  cmd_q;
  logic [5:0]  c_q, nb_q;
  logic [15:0] dist_q, we_q, wl_q, sv_q, rl_q, dp_q;
  logic [4:0]  pos_q;

  // control state
  logic [4:0]  riu;
  logic [5:0]  route_len [cir_pkg::MAX_ROUTES];
  logic [3:0]  r_cnt;
  logic [5:0]  i_cnt;

  // work registers
  logic [15:0] late_c, rel_c, disp_c, rrel, rdisp;
  logic [16:0] finish_c, finish_p;
  logic [5:0]  p, n;
  logic [15:0] dpc, dcn, dpn, d0p, early_p, svc_p, late_n;
  logic        feas, found, rd_ok;
  logic signed [17:0] cost, best_cost;
  logic [3:0]  best_r;
  logic [5:0]  best_i;

  // result being built
  logic [1:0]  res_status;
  logic [3:0]  res_route;
  logic [5:0]  res_pos, res_client, res_len;
  logic signed [17:0] res_delta;

  // memories
  logic [11:0] dist_ra;
  logic [15:0] dist_rd;
  logic [5:0]  win_ra, tim_ra;
  logic [31:0] win_rd;
  logic [47:0] tim_rd;
  logic [8:0]  rt_ra, rt_wa;
  logic        rt_we;
  logic [5:0]  rt_wd, rt_rd;

  logic [5:0]  len_cur;
  logic [4:0]  nr;
  logic [16:0] fin_calc;
  logic [17:0] chk_a, chk_b;
  logic [5:0]  i_dec;

  assign len_cur  = route_len[r_cnt];
  assign i_dec    = i_cnt - 6'd1;
  assign fin_calc = ((d0p > early_p) ? {1'b0, d0p} : {1'b0, early_p}) + {1'b0, svc_p};
  assign chk_a    = {1'b0, finish_p} + {2'b0, dpc};
  assign chk_b    = {1'b0, finish_c} + {2'b0, dcn};

  always_comb begin
    if (riu == 5'd0) begin
      nr = 5'd1;
    end else if (riu > 5'(cir_pkg::MAX_ROUTES)) begin
      nr = 5'(cir_pkg::MAX_ROUTES);
    end else begin
      nr = riu;
    end
  end

  always_comb begin
    stat.cmd        = cmd_q;
    stat.len_zero   = (len_cur == 6'd0);
    stat.scan_last  = ((i_cnt + 6'd1) == len_cur);
    stat.skip       = (rel_c > rdisp) || (disp_c < rrel);
    stat.gap_last   = (i_cnt == len_cur);
    stat.route_last = (({1'b0, r_cnt} + 5'd1) == nr);
    stat.full       = (len_cur >= 6'(cir_pkg::MAX_ROUTE_LEN));
    stat.mv_more    = (i_cnt > best_i);
  end

  // read and write addresses
  always_comb begin
    dist_ra = {c_q, c_q};
    win_ra  = c_q;
    tim_ra  = c_q;
    rt_ra   = {r_cnt, i_cnt[4:0]};
    rt_we   = 1'b0;
    rt_wa   = {r_cnt, len_cur[4:0]};
    rt_wd   = c_q;
    case (op)
      cir_pkg::OP_CL_ISSUE: dist_ra = {6'd0, c_q};
      cir_pkg::OP_G0: begin
        dist_ra = {p, c_q};
        win_ra  = p;
        tim_ra  = p;
      end
      cir_pkg::OP_G1: dist_ra = {6'd0, p};
      cir_pkg::OP_G2: begin
        dist_ra = {c_q, n};
        win_ra  = n;
      end
      cir_pkg::OP_G3:     dist_ra = {p, n};
      cir_pkg::OP_W_TIM:  tim_ra = rt_rd;
      cir_pkg::OP_READ:   rt_ra = {r_cnt, pos_q};
      cir_pkg::OP_MV_RD:  rt_ra = {r_cnt, i_dec[4:0]};
      cir_pkg::OP_APPEND: rt_we = !stat.full;
      cir_pkg::OP_MV_WR: begin
        rt_we = 1'b1;
        rt_wa = {r_cnt, i_cnt[4:0]};
        rt_wd = rt_rd;
      end
      cir_pkg::OP_INS: begin
        rt_we = 1'b1;
        rt_wa = {r_cnt, best_i[4:0]};
      end
      default: ;
    endcase
  end

  cir_ram #(.WIDTH(16), .DEPTH(cir_pkg::MAX_NODES * cir_pkg::MAX_NODES)) u_dist (
    .clk(clk), .we(op == cir_pkg::OP_DIST_WR), .waddr({c_q, nb_q}), .wdata(dist_q),
    .raddr(dist_ra), .rdata(dist_rd)
  );

  cir_ram #(.WIDTH(32), .DEPTH(cir_pkg::MAX_NODES)) u_win (
    .clk(clk), .we(op == cir_pkg::OP_CLIENT_WR), .waddr(c_q), .wdata({we_q, wl_q}),
    .raddr(win_ra), .rdata(win_rd)
  );

  cir_ram #(.WIDTH(48), .DEPTH(cir_pkg::MAX_NODES)) u_tim (
    .clk(clk), .we(op == cir_pkg::OP_CLIENT_WR), .waddr(c_q), .wdata({sv_q, rl_q, dp_q}),
    .raddr(tim_ra), .rdata(tim_rd)
  );

  cir_ram #(.WIDTH(6), .DEPTH(cir_pkg::MAX_ROUTES * cir_pkg::MAX_ROUTE_LEN)) u_route (
    .clk(clk), .we(rt_we), .waddr(rt_wa), .wdata(rt_wd), .raddr(rt_ra), .rdata(rt_rd)
  );

  // config register and route lengths
  always_ff @(posedge clk) begin
    if (rst) begin
      riu <= 5'd1;
      for (int k = 0; k < cir_pkg::MAX_ROUTES; k++) begin
        route_len[k] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        riu <= cfg_wr_data;
      end
      if ((op == cir_pkg::OP_APPEND && !stat.full) || op == cir_pkg::OP_INS) begin
        route_len[r_cnt] <= len_cur + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      cir_pkg::OP_LOAD: begin
        cmd_q      <= cmd;
        c_q        <= node_a;
        nb_q       <= node_b;
        dist_q     <= distance;
        we_q       <= window_early;
        wl_q       <= window_late;
        sv_q       <= service_time;
        rl_q       <= release_at;
        dp_q       <= dispatch_by;
        pos_q      <= position;
        r_cnt      <= (cmd == cir_pkg::CMD_REPAIR) ? 4'd0 : route_sel;
        found      <= 1'b0;
        best_r     <= '0;
        best_i     <= '0;
        best_cost  <= '0;
        rd_ok      <= 1'b0;
        res_status <= cir_pkg::ST_OK;
        res_route  <= '0;
        res_pos    <= '0;
        res_delta  <= '0;
        res_client <= '0;
        res_len    <= '0;
      end
      cir_pkg::OP_APPEND: begin
        res_route <= r_cnt;
        res_pos   <= len_cur;
        if (stat.full) begin
          res_status <= cir_pkg::ST_FULL;
          res_len    <= len_cur;
        end else begin
          res_len <= len_cur + 6'd1;
        end
      end
      cir_pkg::OP_READ: begin
        res_len <= len_cur;
        rd_ok   <= ({1'b0, pos_q} < len_cur);
        if (!({1'b0, pos_q} < len_cur)) begin
          res_status <= cir_pkg::ST_BAD;
        end
      end
      cir_pkg::OP_READ_CAP: begin
        if (rd_ok) begin
          res_client <= rt_rd;
        end
      end
      cir_pkg::OP_BAD: res_status <= cir_pkg::ST_BAD;
      cir_pkg::OP_CL_CAP: begin
        d0p     <= dist_rd;
        early_p <= win_rd[31:16];
        late_c  <= win_rd[15:0];
        svc_p   <= tim_rd[47:32];
        rel_c   <= tim_rd[31:16];
        disp_c  <= tim_rd[15:0];
      end
      cir_pkg::OP_CL_FIN: finish_c <= fin_calc;
      cir_pkg::OP_ROUTE_INIT: begin
        rrel  <= '0;
        rdisp <= 16'hFFFF;
        i_cnt <= '0;
      end
      cir_pkg::OP_W_ACC: begin
        if (tim_rd[31:16] > rrel) begin
          rrel <= tim_rd[31:16];
        end
        if (tim_rd[15:0] < rdisp) begin
          rdisp <= tim_rd[15:0];
        end
        i_cnt <= i_cnt + 6'd1;
      end
      cir_pkg::OP_GAP_INIT: begin
        i_cnt <= '0;
        p     <= '0;
      end
      cir_pkg::OP_G1: begin
        n       <= stat.gap_last ? 6'd0 : rt_rd;
        dpc     <= dist_rd;
        early_p <= win_rd[31:16];
        svc_p   <= tim_rd[47:32];
      end
      cir_pkg::OP_G2: d0p <= dist_rd;
      cir_pkg::OP_G3: begin
        dcn    <= dist_rd;
        late_n <= win_rd[15:0];
      end
      cir_pkg::OP_G4: begin
        dpn      <= dist_rd;
        finish_p <= fin_calc;
      end
      cir_pkg::OP_G5: begin
        feas <= (chk_a < {2'b0, late_c}) && (chk_b < {2'b0, late_n});
        cost <= $signed({2'b0, dpc}) + $signed({2'b0, dcn}) - $signed({2'b0, dpn});
      end
      cir_pkg::OP_G6: begin
        if (feas && (!found || cost < best_cost)) begin
          found     <= 1'b1;
          best_cost <= cost;
          best_r    <= r_cnt;
          best_i    <= i_cnt;
        end
        p     <= n;
        i_cnt <= i_cnt + 6'd1;
      end
      cir_pkg::OP_NEXT_ROUTE: r_cnt <= r_cnt + 4'd1;
      cir_pkg::OP_FIN: begin
        r_cnt      <= best_r;
        res_route  <= best_r;
        res_pos    <= best_i;
        res_delta  <= found ? best_cost : cir_pkg::NO_FEASIBLE;
        res_status <= found ? cir_pkg::ST_OK : cir_pkg::ST_FORCED;
      end
      cir_pkg::OP_FIN_LEN: begin
        if (stat.full) begin
          res_status <= cir_pkg::ST_FULL;
          res_len    <= len_cur;
        end else begin
          i_cnt <= len_cur;
        end
      end
      cir_pkg::OP_MV_WR: i_cnt <= i_dec;
      cir_pkg::OP_INS:   res_len <= len_cur + 6'd1;
      cir_pkg::OP_PUBLISH: begin
        status          <= res_status;
        chosen_route    <= res_route;
        chosen_position <= res_pos;
        delta_cost      <= res_delta;
        read_client     <= res_client;
        route_length    <= res_len;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/cir_ctrl.sv -----
// ----------------------------------------------------------------------------
// cir_ctrl: sequencer of the repair block
// Steps through the command phases and drives one datapath operation a cycle.
// ----------------------------------------------------------------------------
module cir_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cir_pkg::dp_stat_t stat,
  output cir_pkg::op_t      op
);

  typedef enum logic [25:0] {
    S_IDLE   = 26'd1 << 0,
    S_EXEC   = 26'd1 << 1,
    S_RDCAP  = 26'd1 << 2,
    S_C1     = 26'd1 << 3,
    S_C2     = 26'd1 << 4,
    S_RSTART = 26'd1 << 5,
    S_W0     = 26'd1 << 6,
    S_W1     = 26'd1 << 7,
    S_W2     = 26'd1 << 8,
    S_WCHK   = 26'd1 << 9,
    S_G0     = 26'd1 << 10,
    S_G1     = 26'd1 << 11,
    S_G2     = 26'd1 << 12,
    S_G3     = 26'd1 << 13,
    S_G4     = 26'd1 << 14,
    S_G5     = 26'd1 << 15,
    S_G6     = 26'd1 << 16,
    S_NEXTR  = 26'd1 << 17,
    S_FIN    = 26'd1 << 18,
    S_FINL   = 26'd1 << 19,
    S_MCHK   = 26'd1 << 20,
    S_M0     = 26'd1 << 21,
    S_M1     = 26'd1 << 22,
    S_M2     = 26'd1 << 23,
    S_DONE   = 26'd1 << 24,
    S_SPARE  = 26'd1 << 25
  } state_t;

  state_t state, state_next;
  logic   publish;

  assign in_ready = (state == S_IDLE);
  assign publish  = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    op         = cir_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = cir_pkg::OP_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        unique case (stat.cmd)
          cir_pkg::CMD_DIST:   op = cir_pkg::OP_DIST_WR;
          cir_pkg::CMD_CLIENT: op = cir_pkg::OP_CLIENT_WR;
          cir_pkg::CMD_APPEND: op = cir_pkg::OP_APPEND;
          cir_pkg::CMD_READ: begin
            op         = cir_pkg::OP_READ;
            state_next = S_RDCAP;
          end
          cir_pkg::CMD_REPAIR: begin
            op         = cir_pkg::OP_CL_ISSUE;
            state_next = S_C1;
          end
          default: op = cir_pkg::OP_BAD;
        endcase
      end
      S_RDCAP: begin
        op         = cir_pkg::OP_READ_CAP;
        state_next = S_DONE;
      end
      S_C1: begin
        op         = cir_pkg::OP_CL_CAP;
        state_next = S_C2;
      end
      S_C2: begin
        op         = cir_pkg::OP_CL_FIN;
        state_next = S_RSTART;
      end
      S_RSTART: begin
        op         = cir_pkg::OP_ROUTE_INIT;
        state_next = stat.len_zero ? S_WCHK : S_W0;
      end
      S_W0: begin
        op         = cir_pkg::OP_W_ENTRY;
        state_next = S_W1;
      end
      S_W1: begin
        op         = cir_pkg::OP_W_TIM;
        state_next = S_W2;
      end
      S_W2: begin
        op         = cir_pkg::OP_W_ACC;
        state_next = stat.scan_last ? S_WCHK : S_W0;
      end
      S_WCHK: begin
        op         = cir_pkg::OP_GAP_INIT;
        state_next = stat.skip ? S_NEXTR : S_G0;
      end
      S_G0: begin
        op         = cir_pkg::OP_G0;
        state_next = S_G1;
      end
      S_G1: begin
        op         = cir_pkg::OP_G1;
        state_next = S_G2;
      end
      S_G2: begin
        op         = cir_pkg::OP_G2;
        state_next = S_G3;
      end
      S_G3: begin
        op         = cir_pkg::OP_G3;
        state_next = S_G4;
      end
      S_G4: begin
        op         = cir_pkg::OP_G4;
        state_next = S_G5;
      end
      S_G5: begin
        op         = cir_pkg::OP_G5;
        state_next = S_G6;
      end
      S_G6: begin
        op         = cir_pkg::OP_G6;
        state_next = stat.gap_last ? S_NEXTR : S_G0;
      end
      S_NEXTR: begin
        op         = cir_pkg::OP_NEXT_ROUTE;
        state_next = stat.route_last ? S_FIN : S_RSTART;
      end
      S_FIN: begin
        op         = cir_pkg::OP_FIN;
        state_next = S_FINL;
      end
      S_FINL: begin
        op         = cir_pkg::OP_FIN_LEN;
        state_next = stat.full ? S_DONE : S_MCHK;
      end
      S_MCHK:  state_next = stat.mv_more ? S_M0 : S_M2;
      S_M0: begin
        op         = cir_pkg::OP_MV_RD;
        state_next = S_M1;
      end
      S_M1: begin
        op         = cir_pkg::OP_MV_WR;
        state_next = S_MCHK;
      end
      S_M2: begin
        op         = cir_pkg::OP_INS;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (publish) begin
          op         = cir_pkg::OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/cheapest_insertion_repair_core.sv -----
// ----------------------------------------------------------------------------
// cheapest_insertion_repair_core: greedy cheapest-insertion route repair
// Top level: sequencer plus datapath with distance, client and route stores.
// ----------------------------------------------------------------------------
// One word in, one word out. In a repair every gap costs seven steps because
// the distance table has a single read port and each gap needs four distance
// reads. Routes whose release/dispatch window misses the client skip the gap
// tests. One word is in flight at a time; the finished result sits in an
// output register, so the next word is taken while it waits. The stores are
// not cleared at reset, only the route lengths are; load what you read.
module cheapest_insertion_repair_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic [5:0]         node_a,
  input  logic [5:0]         node_b,
  input  logic [15:0]        distance,
  input  logic [15:0]        window_early,
  input  logic [15:0]        window_late,
  input  logic [15:0]        service_time,
  input  logic [15:0]        release_at,
  input  logic [15:0]        dispatch_by,
  input  logic [3:0]         route_sel,
  input  logic [4:0]         position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [3:0]         chosen_route,
  output logic [5:0]         chosen_position,
  output logic signed [17:0] delta_cost,
  output logic [5:0]         read_client,
  output logic [5:0]         route_length
);

  cir_pkg::op_t      op;
  cir_pkg::dp_stat_t stat;

  // sequencer: one operation per cycle
  cir_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .op(op)
  );

  // stores, counters, gap arithmetic and output register
  cir_datapath u_dp (
    .clk(clk), .rst(rst), .op(op), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .cmd(cmd), .node_a(node_a), .node_b(node_b), .distance(distance),
    .window_early(window_early), .window_late(window_late),
    .service_time(service_time), .release_at(release_at), .dispatch_by(dispatch_by),
    .route_sel(route_sel), .position(position), .stat(stat),
    .status(status), .chosen_route(chosen_route), .chosen_position(chosen_position),
    .delta_cost(delta_cost), .read_client(read_client), .route_length(route_length)
  );

  // a taken word closes the input in the cycle after the accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened right after accept");

  // a forced insert always lands at the front of route 0 with the sentinel cost
  a_forced_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == cir_pkg::ST_FORCED |->
      chosen_route == 4'd0 && chosen_position == 6'd0 &&
      delta_cost == cir_pkg::NO_FEASIBLE)
    else $error("forced insert result inconsistent");

  // no route ever grows beyond its capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> route_length <= 6'(cir_pkg::MAX_ROUTE_LEN))
    else $error("route length out of range");

endmodule
